// ----- rtl/core/hbkrd_pkg.sv -----
// Package for the HID boot keyboard report decoder.
// Holds slot count, key event types and the usage-to-ASCII translation.
// No dependencies.
`default_nettype none

package hbkrd_pkg;

	localparam int KEY_SLOTS = 6;

	localparam logic [6:0] MIN_REPORT_LEN = 7'd8;
	localparam logic [7:0] SHIFT_MASK = 8'h22;

	localparam logic [7:0] USAGE_A = 8'h04;
	localparam logic [7:0] USAGE_Z = 8'h1d;
	localparam logic [7:0] USAGE_1 = 8'h1e;
	localparam logic [7:0] USAGE_9 = 8'h26;
	localparam logic [7:0] USAGE_0 = 8'h27;
	localparam logic [7:0] USAGE_ENTER = 8'h28;
	localparam logic [7:0] USAGE_BKSP = 8'h2a;
	localparam logic [7:0] USAGE_TAB = 8'h2b;
	localparam logic [7:0] USAGE_SPACE = 8'h2c;
	localparam logic [7:0] USAGE_MINUS = 8'h2d;
	localparam logic [7:0] USAGE_EQUAL = 8'h2e;
	localparam logic [7:0] USAGE_SEMI = 8'h33;
	localparam logic [7:0] USAGE_QUOTE = 8'h34;
	localparam logic [7:0] USAGE_COMMA = 8'h36;
	localparam logic [7:0] USAGE_DOT = 8'h37;
	localparam logic [7:0] USAGE_SLASH = 8'h38;
	localparam logic [7:0] USAGE_RIGHT = 8'h4f;
	localparam logic [7:0] USAGE_LEFT = 8'h50;
	localparam logic [7:0] USAGE_DOWN = 8'h51;
	localparam logic [7:0] USAGE_UP = 8'h52;

	typedef enum logic [2:0] {
		KIND_CHAR = 3'd0,
		KIND_ENTER = 3'd1,
		KIND_BKSP = 3'd2,
		KIND_NEXT = 3'd3,
		KIND_PREV = 3'd4
	} kind_t;

	typedef struct packed {
		logic hit;
		kind_t kind;
		logic [6:0] ch;
	} event_t;

	function automatic logic [6:0] shifted_digit(input logic [3:0] k);
		logic [6:0] c;
		unique case (k)
			4'd0: c = 7'h21;
			4'd1: c = 7'h40;
			4'd2: c = 7'h23;
			4'd3: c = 7'h24;
			4'd4: c = 7'h25;
			4'd5: c = 7'h5e;
			4'd6: c = 7'h26;
			4'd7: c = 7'h2a;
			4'd8: c = 7'h28;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic event_t translate(input logic [7:0] code, input logic up);
		event_t e;
		logic [7:0] off;
		e.hit = 1'b1;
		e.kind = KIND_CHAR;
		e.ch = 7'h00;
		off = 8'h00;
		if (code >= USAGE_A && code <= USAGE_Z) begin
			off = code - USAGE_A;
			e.ch = (up ? 7'h41 : 7'h61) + off[6:0];
		end else if (code >= USAGE_1 && code <= USAGE_9) begin
			off = code - USAGE_1;
			e.ch = up ? shifted_digit(off[3:0]) : 7'h31 + off[6:0];
		end else begin
			unique case (code)
				USAGE_0: e.ch = up ? 7'h29 : 7'h30;
				USAGE_SPACE: e.ch = 7'h20;
				USAGE_TAB: e.ch = 7'h09;
				USAGE_ENTER: e.kind = KIND_ENTER;
				USAGE_BKSP: e.kind = KIND_BKSP;
				USAGE_RIGHT, USAGE_DOWN: e.kind = KIND_NEXT;
				USAGE_LEFT, USAGE_UP: e.kind = KIND_PREV;
				USAGE_MINUS: e.ch = up ? 7'h5f : 7'h2d;
				USAGE_EQUAL: e.ch = up ? 7'h2b : 7'h3d;
				USAGE_COMMA: e.ch = up ? 7'h3c : 7'h2c;
				USAGE_DOT: e.ch = up ? 7'h3e : 7'h2e;
				USAGE_SLASH: e.ch = up ? 7'h3f : 7'h2f;
				USAGE_SEMI: e.ch = up ? 7'h3a : 7'h3b;
				USAGE_QUOTE: e.ch = up ? 7'h22 : 7'h27;
				default: e.hit = 1'b0;
			endcase
		end
		return e;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hbkrd_in_if.sv -----
// Report channel: valid/ready handshake with the boot keyboard report payload.
// No dependencies.
`default_nettype none

interface hbkrd_in_if;
	logic valid;
	logic ready;
	logic [6:0] report_length;
	logic [7:0] modifier_bits;
	logic [7:0] key_slot_0;
	logic [7:0] key_slot_1;
	logic [7:0] key_slot_2;
	logic [7:0] key_slot_3;
	logic [7:0] key_slot_4;
	logic [7:0] key_slot_5;

	modport source (
		output valid, report_length, modifier_bits,
		output key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
		input ready
	);
	modport sink (
		input valid, report_length, modifier_bits,
		input key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/hbkrd_out_if.sv -----
// Key event channel: valid/ready handshake with one decoded key event.
// No dependencies.
`default_nettype none

interface hbkrd_out_if;
	logic valid;
	logic ready;
	logic [2:0] key_kind;
	logic [6:0] char_code;
	logic last_of_run;

	modport source (output valid, key_kind, char_code, last_of_run, input ready);
	modport sink (input valid, key_kind, char_code, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hbkrd_lane.sv -----
// One slot lane: checks the code against the held keys and translates it.
// Depends on hbkrd_pkg.
`default_nettype none

module hbkrd_lane
	import hbkrd_pkg::*;
(
	input wire logic [7:0] code,
	input wire logic up,
	input wire logic [KEY_SLOTS-1:0][7:0] held_keys,
	output event_t ev
);

	logic held;
	event_t tr;

	always_comb begin
		held = 1'b0;
		for (int j = 0; j < KEY_SLOTS; j++) begin
			if (held_keys[j] == code) held = 1'b1;
		end
	end

	assign tr = translate(code, up);

	always_comb begin
		ev = tr;
		ev.hit = tr.hit & (code != 8'h00) & ~held;
	end

endmodule

`default_nettype wire

// ----- rtl/core/hbkrd_merge.sv -----
// Merge stage: buffers the lane events of one report and issues them in slot
// order through an output register. Depends on hbkrd_pkg and hbkrd_out_if.
`default_nettype none

module hbkrd_merge
	import hbkrd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire event_t [KEY_SLOTS-1:0] lane_ev,
	output logic free,
	hbkrd_out_if.source key_event
);

	logic [KEY_SLOTS-1:0] pend_q;
	event_t [KEY_SLOTS-1:0] ev_q;
	logic out_vld_q;
	kind_t kind_q;
	logic [6:0] ch_q;
	logic last_q;

	logic [KEY_SLOTS-1:0] lowbit;
	logic [KEY_SLOTS-1:0] rest;
	logic [KEY_SLOTS-1:0] new_mask;
	logic open_slot;
	logic mv;
	event_t sel;

	assign lowbit = pend_q & (~pend_q + {{(KEY_SLOTS-1){1'b0}}, 1'b1});
	assign rest = pend_q & ~lowbit;
	assign open_slot = ~out_vld_q | key_event.ready;
	assign mv = open_slot & (pend_q != '0);
	assign free = ((mv ? rest : pend_q) == '0);

	always_comb begin
		sel = '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			new_mask[i] = lane_ev[i].hit;
			if (lowbit[i]) sel = sel | ev_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= new_mask;
			end else if (mv) begin
				pend_q <= rest;
			end
			if (mv) begin
				out_vld_q <= 1'b1;
			end else if (key_event.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) ev_q <= lane_ev;
		if (mv) begin
			kind_q <= sel.kind;
			ch_q <= sel.ch;
			last_q <= (rest == '0);
		end
	end

	assign key_event.valid = out_vld_q;
	assign key_event.key_kind = kind_q;
	assign key_event.char_code = ch_q;
	assign key_event.last_of_run = last_q;

endmodule

`default_nettype wire

// ----- rtl/core/hid_boot_keyboard_report_decoder.sv -----
// HID boot keyboard report decoder, top level.
// Depends on hbkrd_pkg, hbkrd_in_if, hbkrd_out_if, hbkrd_lane, hbkrd_merge.
//
// Channels: report (sink) takes one boot keyboard report per transaction;
// key_event (source) gives one decoded key event per transaction, with
// last_of_run set on the final event of a report.
// Six lanes compare each slot against the held keys and translate it in the
// cycle the report is accepted; the held keys are replaced at that edge.
// A report shorter than 8 bytes is accepted and dropped, state unchanged.
// Each accepted report's events are registered in the event buffer, then
// issued through the output register. Throughput: the merge stage issues one
// event per cycle while key_event is not stalled; the next report is accepted
// in the cycle the last event of the current one enters the output register.
// Reset clears the held keys to zero and empties the event buffer.
// While key_event is stalled the output register holds and report is not
// accepted once the buffer holds pending events.
`default_nettype none

module hid_boot_keyboard_report_decoder
	import hbkrd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	hbkrd_in_if.sink report,
	hbkrd_out_if.source key_event
);

	logic [5:0][7:0] slots;
	logic [KEY_SLOTS-1:0][7:0] held_q;
	event_t [KEY_SLOTS-1:0] lane_ev;
	logic up;
	logic accept;
	logic load;
	logic free;

	assign slots = {report.key_slot_5, report.key_slot_4, report.key_slot_3,
		report.key_slot_2, report.key_slot_1, report.key_slot_0};
	assign up = (report.modifier_bits & SHIFT_MASK) != 8'h00;
	assign report.ready = free;
	assign accept = report.valid & free;
	assign load = accept & (report.report_length >= MIN_REPORT_LEN);

	for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
		hbkrd_lane u_lane (
			.code(slots[i]),
			.up(up),
			.held_keys(held_q),
			.ev(lane_ev[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (load) begin
			held_q <= slots[KEY_SLOTS-1:0];
		end
	end

	hbkrd_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.lane_ev(lane_ev),
		.free(free),
		.key_event(key_event)
	);

endmodule

`default_nettype wire

// ----- tb/sv/hid_boot_keyboard_report_decoder_checker.sv -----
// Checker for the HID boot keyboard report decoder: watches the report and key event
// channels, predicts the key events of each accepted report and compares them in order.
// Depends on hbkrd_pkg, hbkrd_in_if and hbkrd_out_if.
`timescale 1ns / 1ps

module hid_boot_keyboard_report_decoder_checker
	import hbkrd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	hbkrd_in_if report,
	hbkrd_out_if key_event,
	output int fail_count,
	output int pending
);

	typedef struct packed {
		kind_t kind;
		logic [6:0] ch;
		logic last;
	} key_evt_t;

	key_evt_t expected_keys[$];
	logic [7:0] held_keys [KEY_SLOTS];

	function automatic logic decode_usage(input logic [7:0] code, input logic up,
			output kind_t kind, output logic [6:0] ch);
		string shifted_row;
		logic [7:0] base;
		shifted_row = "!@#$%^&*(";
		kind = KIND_CHAR;
		ch = 7'd0;
		if (code >= USAGE_A && code <= USAGE_Z) begin
			base = up ? "A" : "a";
			ch = 7'(base + code - USAGE_A);
		end else if (code >= USAGE_1 && code <= USAGE_9) begin
			base = "1";
			ch = up ? 7'(shifted_row[code - USAGE_1]) : 7'(base + code - USAGE_1);
		end else begin
			case (code)
				USAGE_0: ch = 7'(up ? ")" : "0");
				USAGE_SPACE: ch = 7'(" ");
				USAGE_TAB: ch = 7'd9;
				USAGE_ENTER: kind = KIND_ENTER;
				USAGE_BKSP: kind = KIND_BKSP;
				USAGE_RIGHT, USAGE_DOWN: kind = KIND_NEXT;
				USAGE_LEFT, USAGE_UP: kind = KIND_PREV;
				USAGE_MINUS: ch = 7'(up ? "_" : "-");
				USAGE_EQUAL: ch = 7'(up ? "+" : "=");
				USAGE_COMMA: ch = 7'(up ? "<" : ",");
				USAGE_DOT: ch = 7'(up ? ">" : ".");
				USAGE_SLASH: ch = 7'(up ? "?" : "/");
				USAGE_SEMI: ch = 7'(up ? ":" : ";");
				USAGE_QUOTE: ch = 7'(up ? "\"" : "'");
				default: return 1'b0;
			endcase
		end
		return 1'b1;
	endfunction

	function automatic void predict_report(input logic [6:0] len, input logic [7:0] mods,
			input logic [7:0] codes [KEY_SLOTS]);
		key_evt_t run [KEY_SLOTS];
		int n;
		logic held;
		logic up;
		kind_t kind;
		logic [6:0] ch;
		if (len < MIN_REPORT_LEN)
			return;
		up = (mods & SHIFT_MASK) != 8'h00;
		n = 0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (codes[i] == 8'h00)
				continue;
			held = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++)
				held |= held_keys[j] == codes[i];
			if (held || !decode_usage(codes[i], up, kind, ch))
				continue;
			run[n] = '{kind: kind, ch: ch, last: 1'b0};
			n++;
		end
		for (int k = 0; k < n; k++) begin
			run[k].last = k == n - 1;
			expected_keys.push_back(run[k]);
		end
		held_keys = codes;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		key_evt_t want;
		logic [7:0] codes [KEY_SLOTS];
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++)
				held_keys[i] = 8'h00;
			expected_keys.delete();
			fail_count = 0;
		end else begin
			if (key_event.valid && key_event.ready) begin
				if (expected_keys.size() == 0) begin
					$display("%0t: unexpected key event: kind %0d char %h last %b", $time,
						key_event.key_kind, key_event.char_code, key_event.last_of_run);
					fail_count++;
				end else begin
					want = expected_keys.pop_front();
					if (key_event.key_kind !== want.kind || key_event.char_code !== want.ch
							|| key_event.last_of_run !== want.last) begin
						$display("%0t: key event mismatch: expected kind %0d char %h last %b, %s",
							$time, want.kind, want.ch, want.last,
							$sformatf("actual kind %0d char %h last %b", key_event.key_kind,
							key_event.char_code, key_event.last_of_run));
						fail_count++;
					end
				end
			end
			if (report.valid && report.ready) begin
				codes = '{report.key_slot_0, report.key_slot_1, report.key_slot_2,
					report.key_slot_3, report.key_slot_4, report.key_slot_5};
				predict_report(report.report_length, report.modifier_bits, codes);
			end
		end
		pending = expected_keys.size();
	end

endmodule

// ----- tb/sv/hid_boot_keyboard_report_decoder_test.sv -----
// Top of the HID boot keyboard report decoder test: clock, reset, report stimulus and
// random stalls on the key event channel; the verdict comes from the checker's count.
// Depends on hbkrd_pkg, the channel interfaces, the decoder and its checker.
`timescale 1ns / 1ps

module hid_boot_keyboard_report_decoder_test;
	import hbkrd_pkg::*;

	localparam int PHASE_REPORTS = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic [7:0] prev_slots [KEY_SLOTS] = '{default: 8'h00};

	localparam logic [7:0] MISC_KEYS [14] = '{USAGE_0, USAGE_ENTER, USAGE_BKSP, USAGE_TAB,
		USAGE_SPACE, USAGE_MINUS, USAGE_EQUAL, USAGE_SEMI, USAGE_QUOTE, USAGE_COMMA,
		USAGE_DOT, USAGE_SLASH, USAGE_RIGHT, USAGE_UP};

	hbkrd_in_if report_ch();
	hbkrd_out_if event_ch();

	hid_boot_keyboard_report_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.report(report_ch),
		.key_event(event_ch)
	);

	hid_boot_keyboard_report_decoder_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.report(report_ch),
		.key_event(event_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #6 clk = ~clk;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		event_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_report(input logic [6:0] len, input logic [7:0] mods,
			input logic [7:0] codes [KEY_SLOTS]);
		while ($urandom_range(99) < send_idle_pct) begin
			report_ch.valid <= 1'b0;
			@(posedge clk);
		end
		report_ch.valid <= 1'b1;
		report_ch.report_length <= len;
		report_ch.modifier_bits <= mods;
		report_ch.key_slot_0 <= codes[0];
		report_ch.key_slot_1 <= codes[1];
		report_ch.key_slot_2 <= codes[2];
		report_ch.key_slot_3 <= codes[3];
		report_ch.key_slot_4 <= codes[4];
		report_ch.key_slot_5 <= codes[5];
		@(posedge clk);
		while (!report_ch.ready)
			@(posedge clk);
	endtask

	task automatic drain(input int settle);
		report_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 8'($urandom_range(USAGE_A, USAGE_0));
		if (r < 75)
			return MISC_KEYS[$urandom_range(13)];
		if (r < 88)
			return 8'($urandom_range(USAGE_RIGHT, USAGE_UP));
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic random_report(output logic [6:0] len, output logic [7:0] mods,
			output logic [7:0] codes [KEY_SLOTS]);
		int r;
		int m;
		r = $urandom_range(99);
		m = $urandom_range(3);
		mods = m == 0 ? 8'($urandom) : m == 1 ? SHIFT_MASK & 8'($urandom) : 8'h00;
		len = $urandom_range(3) == 0 ? 7'($urandom_range(8, 127)) : MIN_REPORT_LEN;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (r < 70) begin
				m = $urandom_range(99);
				if (m < 40 && prev_slots[i] != 8'h00)
					codes[i] = prev_slots[i];
				else if (m < 45 && i > 0)
					codes[i] = codes[i - 1];
				else if (m < 75)
					codes[i] = pick_key();
				else
					codes[i] = 8'h00;
			end else if (r < 90) begin
				codes[i] = 8'($urandom);
			end else begin
				codes[i] = 8'h00;
			end
		end
		if (r >= 70 && r < 80)
			len = 7'($urandom);
		else if (r >= 80 && r < 90)
			len = 7'($urandom_range(0, 7));
		prev_slots = codes;
	endtask

	initial begin : stimulus
		logic [6:0] len;
		logic [7:0] mods;
		logic [7:0] codes [KEY_SLOTS];
		int sent;
		report_ch.valid = 1'b0;
		report_ch.report_length = 7'd0;
		report_ch.modifier_bits = 8'h00;
		report_ch.key_slot_0 = 8'h00;
		report_ch.key_slot_1 = 8'h00;
		report_ch.key_slot_2 = 8'h00;
		report_ch.key_slot_3 = 8'h00;
		report_ch.key_slot_4 = 8'h00;
		report_ch.key_slot_5 = 8'h00;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		send_idle_pct = 27;
		recv_idle_pct = 63;

		send_report(7'd8, 8'h00, '{default: 8'h00});
		send_report(7'd8, 8'h00, '{USAGE_A, USAGE_Z, USAGE_1, USAGE_9, USAGE_0, USAGE_SPACE});
		send_report(7'd8, 8'h02, '{USAGE_TAB, USAGE_ENTER, USAGE_BKSP, USAGE_MINUS,
			USAGE_EQUAL, USAGE_SEMI});
		send_report(7'd64, 8'h20, '{USAGE_QUOTE, USAGE_COMMA, USAGE_DOT, USAGE_SLASH,
			USAGE_A, USAGE_Z});
		send_report(7'd127, 8'hff, '{8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23});
		send_report(7'd8, 8'hdd, '{8'h24, 8'h25, USAGE_9, USAGE_0, USAGE_RIGHT, USAGE_LEFT});
		send_report(7'd8, 8'h22, '{USAGE_DOWN, USAGE_UP, 8'h24, 8'h25, USAGE_9, USAGE_0});
		send_report(7'd8, 8'h00, '{default: 8'h00});
		send_report(7'd8, 8'h02, '{8'h24, 8'h25, USAGE_9, USAGE_0, USAGE_SEMI, USAGE_QUOTE});
		send_report(7'd7, 8'h00, '{8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09});
		send_report(7'd0, 8'hff, '{default: 8'hff});
		send_report(7'd8, 8'h00, '{8'h05, 8'h05, 8'h05, 8'h00, 8'h00, 8'h00});
		send_report(7'd8, 8'h00, '{8'h05, 8'h01, 8'h02, 8'h03, 8'hff, 8'h29});
		send_report(7'd8, 8'h02, '{8'h01, 8'hff, 8'h29, 8'h2f, USAGE_A, USAGE_A});
		send_report(7'd8, 8'h00, '{USAGE_MINUS, USAGE_EQUAL, USAGE_COMMA, USAGE_DOT,
			USAGE_SLASH, USAGE_TAB});
		send_report(7'd8, 8'h00, '{USAGE_SPACE, USAGE_BKSP, USAGE_ENTER, USAGE_RIGHT,
			USAGE_LEFT, USAGE_DOWN});
		send_report(7'd8, 8'h02, '{USAGE_UP, USAGE_QUOTE, USAGE_SEMI, USAGE_SPACE, 8'h80,
			8'he0});
		drain(4);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 27 : phase == 1 ? 63 : 0;
			recv_idle_pct = phase == 0 ? 63 : phase == 1 ? 27 : 0;
			sent = 0;
			while (sent < PHASE_REPORTS) begin
				random_report(len, mods, codes);
				send_report(len, mods, codes);
				sent++;
			end
		end

		drain(16);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#2400000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
